@@ hw/rtl/twab_pkg.sv @@
package twab_pkg;

   // field widths
   localparam int TIME_W  = 32;
   localparam int COORD_W = 12;
   localparam int LIGHT_W = 12;
   localparam int DUTY_W  = 12;
   localparam int MS_W    = 16;
   localparam int WAKE_W  = 20;
   localparam int GAIN_W  = 9;
   localparam int SMOOTH_W = 20;
   localparam int FRAC_W  = 8;
   localparam int LEVEL_W = 8;

   // configuration port
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 20;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_TOUCH_MIN_X = 3'd0,
      REG_TOUCH_MAX_X = 3'd1,
      REG_TOUCH_MIN_Y = 3'd2,
      REG_TOUCH_MAX_Y = 3'd3,
      REG_NOISE_MS    = 3'd4,
      REG_RELEASE_MS  = 3'd5,
      REG_WAKE_MS     = 3'd6,
      REG_SMOOTH_GAIN = 3'd7
   } csr_index_type;

   // register reset values
   localparam logic [COORD_W-1:0] RST_TOUCH_MIN_X = 12'd400;
   localparam logic [COORD_W-1:0] RST_TOUCH_MAX_X = 12'd3836;
   localparam logic [COORD_W-1:0] RST_TOUCH_MIN_Y = 12'd350;
   localparam logic [COORD_W-1:0] RST_TOUCH_MAX_Y = 12'd3850;
   localparam logic [MS_W-1:0]    RST_NOISE_MS    = 16'd50;
   localparam logic [MS_W-1:0]    RST_RELEASE_MS  = 16'd50;
   localparam logic [WAKE_W-1:0]  RST_WAKE_MS     = 20'd20000;
   localparam logic [GAIN_W-1:0]  RST_SMOOTH_GAIN = 9'd26;

   // backlight levels
   localparam int LEVEL_FULL_SCALE = 255;
   localparam int WAKE_LEVEL       = 150;
   localparam int DARK_POINT       = 400;
   localparam int DUTY_MAX         = 4095;
   localparam int DUTY_STEP        = DUTY_MAX / LEVEL_FULL_SCALE;
   localparam int GAIN_ONE         = 256;

   // WAKE_LEVEL / DARK_POINT reduces to 3/8 exactly
   localparam int MAP_MUL   = 3;
   localparam int MAP_SHIFT = 3;

   // multiply-accumulate datapath for the average, two gain bits per step
   localparam int MAC_W      = 31;
   localparam int MAC_DIGITS = (GAIN_W + 1) / 2;
   localparam int MAC_CNT_W  = $clog2(MAC_DIGITS);

   function automatic logic [DUTY_W-1:0] level_to_duty(input logic [LEVEL_W-1:0] level);
      logic [DUTY_W-1:0]   lvl_clamp;
      logic [2*DUTY_W-1:0] prod;
      begin
         lvl_clamp = {{(DUTY_W-LEVEL_W){1'b0}}, level};
         if (lvl_clamp > DUTY_W'(LEVEL_FULL_SCALE)) begin
            lvl_clamp = DUTY_W'(LEVEL_FULL_SCALE);
         end
         prod = DUTY_W'(DUTY_STEP) * lvl_clamp;
         level_to_duty = prod[DUTY_W-1:0];
      end
   endfunction

   localparam logic [DUTY_W-1:0] WAKE_DUTY = level_to_duty(LEVEL_W'(WAKE_LEVEL));

endpackage

@@ hw/rtl/twab_if.sv @@
interface twab_req_if;
   logic                          valid;
   logic                          ready;
   logic [twab_pkg::TIME_W-1:0]   now_ms;
   logic                          pressed;
   logic [twab_pkg::COORD_W-1:0]  raw_x;
   logic [twab_pkg::COORD_W-1:0]  raw_y;
   logic [twab_pkg::LIGHT_W-1:0]  light_level;

   modport source (output valid, now_ms, pressed, raw_x, raw_y, light_level, input ready);
   modport sink   (input valid, now_ms, pressed, raw_x, raw_y, light_level, output ready);
endinterface

interface twab_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [twab_pkg::DUTY_W-1:0]   duty;
   logic                          wake_active;
   logic                          touch_valid;

   modport source (output valid, duty, wake_active, touch_valid, input ready);
   modport sink   (input valid, duty, wake_active, touch_valid, output ready);
endinterface

interface twab_csr_if;
   logic                             valid;
   logic                             ready;
   logic [twab_pkg::CSR_IDX_W-1:0]   index;
   logic [twab_pkg::CSR_DATA_W-1:0]  data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

@@ hw/rtl/touch_wake_auto_backlight_core.sv @@
// channel   dir   word
// req_if    in    now_ms[31:0], pressed, raw_x[11:0], raw_y[11:0], light_level[11:0]
// rsp_if    out   duty[11:0], wake_active, touch_valid
// csr_if    in    index[2:0], data[19:0] (register write, always ready)
//
// A word accepted during the wake period passes TOUCH, WAKE, EXP and OUT; otherwise
// MUL, RND and LVL come between EXP and OUT. The smoothing multiply steps
// through the gain two bits a cycle (5 steps) on a shared add. One word in work.
// reset is synchronous; it loads the register defaults and clears the sequencer and persistent state.
// A finished result waits in the output register while the next word is taken;
// a word finishing while that register is still full holds until it drains.
module touch_wake_auto_backlight_core (
   input  logic            clock,
   input  logic            reset,
   twab_req_if.sink        req_if,
   twab_rsp_if.source      rsp_if,
   twab_csr_if.sink        csr_if
);

   typedef enum logic [7:0] {
      ST_IDLE  = 8'b0000_0001,
      ST_TOUCH = 8'b0000_0010,
      ST_WAKE  = 8'b0000_0100,
      ST_EXP   = 8'b0000_1000,
      ST_MUL   = 8'b0001_0000,
      ST_RND   = 8'b0010_0000,
      ST_LVL   = 8'b0100_0000,
      ST_OUT   = 8'b1000_0000
   } state_type;

   localparam int TW = twab_pkg::TIME_W;
   localparam int MW = twab_pkg::MAC_W;

   // configuration
   logic [twab_pkg::COORD_W-1:0] min_x_ff, max_x_ff, min_y_ff, max_y_ff;
   logic [twab_pkg::MS_W-1:0]    noise_ff, release_ff;
   logic [twab_pkg::WAKE_W-1:0]  wake_ms_ff;
   logic [twab_pkg::GAIN_W-1:0]  gain_ff;

   // sequencer and persistent state
   state_type                      state_ff, state_in;
   logic                           held_ff, held_in;
   logic [TW-1:0]                  press_start_ff, press_start_in;
   logic [TW-1:0]                  last_valid_ff, last_valid_in;
   logic                           valid_ff, valid_in;
   logic                           wake_ff, wake_in;
   logic [TW-1:0]                  deadline_ff, deadline_in;
   logic [twab_pkg::SMOOTH_W-1:0]  smooth_ff, smooth_in;
   logic                           rsp_valid_ff, rsp_valid_in;

   // captured word and working registers
   logic [TW-1:0]                  now_ff, now_in;
   logic                           pressed_ff, pressed_in;
   logic [twab_pkg::COORD_W-1:0]   x_ff, x_in, y_ff, y_in;
   logic [twab_pkg::LIGHT_W-1:0]   light_ff, light_in;
   logic                           wake_out_ff, wake_out_in;
   logic signed [MW-1:0]           acc_ff, acc_in;
   logic signed [MW-1:0]           d_ff, d_in;
   logic signed [MW-1:0]           d3_ff, d3_in;
   logic [2*twab_pkg::MAC_DIGITS-1:0] g_ff, g_in;
   logic [twab_pkg::MAC_CNT_W-1:0] cnt_ff, cnt_in;
   logic [twab_pkg::LEVEL_W-1:0]   level_ff, level_in;
   logic [twab_pkg::DUTY_W-1:0]    duty_ff, duty_in;
   logic                           wake_act_ff, wake_act_in;
   logic                           touch_ff, touch_in;

   // combinational helpers
   logic                           req_fire, rsp_free;
   logic [TW-1:0]                  start_sel, sub_b, elapsed, diff;
   logic [twab_pkg::MS_W-1:0]      thr;
   logic                           elapsed_ok, in_window;
   logic [twab_pkg::GAIN_W-1:0]    gain_clamp;
   logic signed [MW-1:0]           pp;
   logic [MW-1:0]                  rnd;
   logic [twab_pkg::LIGHT_W-1:0]   s_int;
   logic [twab_pkg::LIGHT_W-1:0]   dark_gap;
   logic [twab_pkg::LIGHT_W-1:0]   scaled;

   assign req_if.ready = (state_ff == ST_IDLE);
   assign req_fire     = req_if.valid && req_if.ready;
   assign rsp_free     = !rsp_valid_ff || rsp_if.ready;
   assign csr_if.ready = 1'b1;

   assign rsp_if.valid       = rsp_valid_ff;
   assign rsp_if.duty        = duty_ff;
   assign rsp_if.wake_active = wake_act_ff;
   assign rsp_if.touch_valid = touch_ff;

   always_comb begin
      state_in       = state_ff;
      held_in        = held_ff;
      press_start_in = press_start_ff;
      last_valid_in  = last_valid_ff;
      valid_in       = valid_ff;
      wake_in        = wake_ff;
      deadline_in    = deadline_ff;
      smooth_in      = smooth_ff;
      rsp_valid_in   = rsp_valid_ff;
      now_in         = now_ff;
      pressed_in     = pressed_ff;
      x_in           = x_ff;
      y_in           = y_ff;
      light_in       = light_ff;
      wake_out_in    = wake_out_ff;
      acc_in         = acc_ff;
      d_in           = d_ff;
      d3_in          = d3_ff;
      g_in           = g_ff;
      cnt_in         = cnt_ff;
      level_in       = level_ff;
      duty_in        = duty_ff;
      wake_act_in    = wake_act_ff;
      touch_in       = touch_ff;

      // touch timing shares one subtract and compare
      start_sel  = held_ff ? press_start_ff : now_ff;
      sub_b      = pressed_ff ? start_sel : last_valid_ff;
      thr        = pressed_ff ? noise_ff : release_ff;
      elapsed    = now_ff - sub_b;
      elapsed_ok = elapsed >= {{(TW-twab_pkg::MS_W){1'b0}}, thr};
      in_window  = (x_ff >= min_x_ff) && (x_ff <= max_x_ff) &&
                   (y_ff >= min_y_ff) && (y_ff <= max_y_ff);

      diff       = now_ff - deadline_ff;
      gain_clamp = (gain_ff > twab_pkg::GAIN_W'(twab_pkg::GAIN_ONE)) ?
                   twab_pkg::GAIN_W'(twab_pkg::GAIN_ONE) : gain_ff;

      case (g_ff[1:0])
         2'd0:    pp = '0;
         2'd1:    pp = d_ff;
         2'd2:    pp = d_ff <<< 1;
         2'd3:    pp = d3_ff;
         default: pp = '0;
      endcase

      rnd      = acc_ff + MW'(128);
      s_int    = smooth_ff[twab_pkg::SMOOTH_W-1:twab_pkg::FRAC_W];
      dark_gap = twab_pkg::LIGHT_W'(twab_pkg::DARK_POINT) - s_int;
      scaled   = dark_gap * twab_pkg::LIGHT_W'(twab_pkg::MAP_MUL);

      if (rsp_valid_ff && rsp_if.ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               now_in     = req_if.now_ms;
               pressed_in = req_if.pressed;
               x_in       = req_if.raw_x;
               y_in       = req_if.raw_y;
               light_in   = req_if.light_level;
               state_in   = ST_TOUCH;
            end
         end
         ST_TOUCH: begin
            if (pressed_ff) begin
               held_in        = 1'b1;
               press_start_in = start_sel;
               if (elapsed_ok) begin
                  last_valid_in = now_ff;
                  valid_in      = in_window;
               end else begin
                  valid_in = 1'b0;
               end
            end else if (held_ff && elapsed_ok) begin
               held_in  = 1'b0;
               valid_in = 1'b0;
            end
            d_in     = $signed({11'b0, light_ff, 8'b0}) - $signed({11'b0, smooth_ff});
            acc_in   = $signed({3'b0, smooth_ff, 8'b0});
            state_in = ST_WAKE;
         end
         ST_WAKE: begin
            if (valid_ff) begin
               wake_in     = 1'b1;
               deadline_in = now_ff + {{(TW-twab_pkg::WAKE_W){1'b0}}, wake_ms_ff};
            end
            d3_in    = d_ff + (d_ff <<< 1);
            g_in     = {1'b0, gain_clamp};
            cnt_in   = '0;
            state_in = ST_EXP;
         end
         ST_EXP: begin
            wake_out_in = wake_ff;
            if (wake_ff) begin
               // the wake period ends once time has passed the deadline
               if ((diff != '0) && !diff[TW-1]) begin
                  wake_in = 1'b0;
               end
               state_in = ST_OUT;
            end else begin
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            acc_in = acc_ff + pp;
            d_in   = d_ff <<< 2;
            d3_in  = d3_ff <<< 2;
            g_in   = g_ff >> 2;
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == twab_pkg::MAC_CNT_W'(twab_pkg::MAC_DIGITS - 1)) begin
               state_in = ST_RND;
            end
         end
         ST_RND: begin
            smooth_in = rnd[twab_pkg::SMOOTH_W+twab_pkg::FRAC_W-1:twab_pkg::FRAC_W];
            state_in  = ST_LVL;
         end
         ST_LVL: begin
            if (s_int >= twab_pkg::LIGHT_W'(twab_pkg::DARK_POINT)) begin
               level_in = '0;
            end else begin
               level_in = twab_pkg::LEVEL_W'(scaled >> twab_pkg::MAP_SHIFT);
            end
            state_in = ST_OUT;
         end
         ST_OUT: begin
            // hold until the output register is free
            if (rsp_free) begin
               duty_in      = wake_out_ff ? twab_pkg::WAKE_DUTY :
                              twab_pkg::level_to_duty(level_ff);
               wake_act_in  = wake_out_ff;
               touch_in     = valid_ff;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         min_x_ff   <= twab_pkg::RST_TOUCH_MIN_X;
         max_x_ff   <= twab_pkg::RST_TOUCH_MAX_X;
         min_y_ff   <= twab_pkg::RST_TOUCH_MIN_Y;
         max_y_ff   <= twab_pkg::RST_TOUCH_MAX_Y;
         noise_ff   <= twab_pkg::RST_NOISE_MS;
         release_ff <= twab_pkg::RST_RELEASE_MS;
         wake_ms_ff <= twab_pkg::RST_WAKE_MS;
         gain_ff    <= twab_pkg::RST_SMOOTH_GAIN;
      end else if (csr_if.valid && csr_if.ready) begin
         case (twab_pkg::csr_index_type'(csr_if.index))
            twab_pkg::REG_TOUCH_MIN_X: min_x_ff   <= csr_if.data[twab_pkg::COORD_W-1:0];
            twab_pkg::REG_TOUCH_MAX_X: max_x_ff   <= csr_if.data[twab_pkg::COORD_W-1:0];
            twab_pkg::REG_TOUCH_MIN_Y: min_y_ff   <= csr_if.data[twab_pkg::COORD_W-1:0];
            twab_pkg::REG_TOUCH_MAX_Y: max_y_ff   <= csr_if.data[twab_pkg::COORD_W-1:0];
            twab_pkg::REG_NOISE_MS:    noise_ff   <= csr_if.data[twab_pkg::MS_W-1:0];
            twab_pkg::REG_RELEASE_MS:  release_ff <= csr_if.data[twab_pkg::MS_W-1:0];
            twab_pkg::REG_WAKE_MS:     wake_ms_ff <= csr_if.data[twab_pkg::WAKE_W-1:0];
            twab_pkg::REG_SMOOTH_GAIN: gain_ff    <= csr_if.data[twab_pkg::GAIN_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         held_ff        <= 1'b0;
         press_start_ff <= '0;
         last_valid_ff  <= '0;
         valid_ff       <= 1'b0;
         wake_ff        <= 1'b0;
         deadline_ff    <= '0;
         smooth_ff      <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         held_ff        <= held_in;
         press_start_ff <= press_start_in;
         last_valid_ff  <= last_valid_in;
         valid_ff       <= valid_in;
         wake_ff        <= wake_in;
         deadline_ff    <= deadline_in;
         smooth_ff      <= smooth_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      now_ff      <= now_in;
      pressed_ff  <= pressed_in;
      x_ff        <= x_in;
      y_ff        <= y_in;
      light_ff    <= light_in;
      wake_out_ff <= wake_out_in;
      acc_ff      <= acc_in;
      d_ff        <= d_in;
      d3_ff       <= d3_in;
      g_ff        <= g_in;
      cnt_ff      <= cnt_in;
      level_ff    <= level_in;
      duty_ff     <= duty_in;
      wake_act_ff <= wake_act_in;
      touch_ff    <= touch_in;
   end

endmodule
